>>> src/pfrt_pkg.sv
// ----------------------------------------------------------------------------
// pfrt_pkg
// shared constants, codes and types of the page frame replacement table
// ----------------------------------------------------------------------------
package pfrt_pkg;

  localparam int NUM_FRAMES = 16;
  localparam int IDX_W      = (NUM_FRAMES > 1) ? $clog2(NUM_FRAMES) : 1;
  localparam int CNT_W      = $clog2(NUM_FRAMES + 1);
  localparam int PAGE_W     = 24;
  localparam int PIN_W      = 8;
  localparam int WORD_W     = 32;
  localparam int FI_W       = 4;
  localparam int OP_W       = 3;
  localparam int ST_W       = 3;

  localparam logic [OP_W-1:0] OP_PIN      = 3'd0;
  localparam logic [OP_W-1:0] OP_UNPIN    = 3'd1;
  localparam logic [OP_W-1:0] OP_DIRTY    = 3'd2;
  localparam logic [OP_W-1:0] OP_FORCE    = 3'd3;
  localparam logic [OP_W-1:0] OP_FLUSH    = 3'd4;
  localparam logic [OP_W-1:0] OP_SHUTDOWN = 3'd5;
  localparam logic [OP_W-1:0] OP_QUERY    = 3'd6;

  localparam logic [ST_W-1:0] ST_OK         = 3'd0;
  localparam logic [ST_W-1:0] ST_NO_UNPIN   = 3'd1;
  localparam logic [ST_W-1:0] ST_NOT_RES    = 3'd2;
  localparam logic [ST_W-1:0] ST_EMPTY      = 3'd3;
  localparam logic [ST_W-1:0] ST_PINNED_END = 3'd4;

  localparam logic [1:0] POL_FIFO = 2'd0;
  localparam logic [1:0] POL_LRU  = 2'd1;
  localparam logic [1:0] POL_LFU  = 2'd2;

  localparam logic REG_POLICY = 1'b0;
  localparam logic REG_FRAMES = 1'b1;

  localparam logic [PIN_W-1:0] PIN_MAX = 8'd255;

  typedef struct packed {
    logic [PAGE_W-1:0] page;
    logic              valid;
    logic [PIN_W-1:0]  pin;
    logic [WORD_W-1:0] value;
  } entry_t;

  typedef struct packed {
    logic hit;
    logic empty;
    logic unpinned;
    logic less;
  } cmp_t;

endpackage

>>> src/pfrt_cmp_unit.sv
// ----------------------------------------------------------------------------
// pfrt_cmp_unit
// shared compare unit, looks at one frame per cycle for the sequencer
// ----------------------------------------------------------------------------
module pfrt_cmp_unit (
  input  pfrt_pkg::entry_t                  entry,
  input  logic [pfrt_pkg::PAGE_W-1:0]       key,
  input  logic [pfrt_pkg::WORD_W-1:0]       best,
  input  logic                              best_found,
  output pfrt_pkg::cmp_t                    res
);

  always_comb begin
    res.hit      = entry.valid && (entry.page == key);
    res.empty    = !entry.valid;
    res.unpinned = (entry.pin == '0);
    // candidate beats the best so far (strict, so frames scanned earlier win ties)
    res.less     = res.unpinned && (!best_found || (entry.value < best));
  end

endmodule

>>> src/page_frame_replacement_table.sv
// ----------------------------------------------------------------------------
// page_frame_replacement_table
// frame table bookkeeping of a buffer pool with fifo, lru and lfu replacement
// ----------------------------------------------------------------------------
// One request is taken at a time; in_stall stays high until its last result
// beat has been loaded into the output register. A small sequencer walks the
// frames in use one per cycle through a single shared compare unit. Unpin,
// mark dirty and force go through accept, one pass and decide; pin goes
// through accept, a pointer step, one pass and decide, and the pointer step
// repeats while a rotating pointer has to be wrapped back into a pool that
// has shrunk; a pin miss adds a fill step, and under fifo or lfu with no empty
// frame a second pass from the rotating pointer before it; flush all and
// shutdown go through accept, one pass that emits the write-back beats as it
// goes, and a closing beat; query and unknown opcodes go through accept and
// decide. Stalls on the output channel hold the decide, fill, write-back and
// closing steps. The frame table sits in flip-flops and the valid bits clear
// at once on reset and at shutdown, so there is no clearing pass.
// ----------------------------------------------------------------------------
module page_frame_replacement_table (
  input  logic                              clk,
  input  logic                              rst,
  // configuration writes
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic                              cfg_index,
  input  logic [4:0]                        cfg_data,
  // request channel
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [pfrt_pkg::OP_W-1:0]         opcode,
  input  logic [pfrt_pkg::PAGE_W-1:0]       page_number,
  input  logic [3:0]                        frame_select,
  // result channel
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [pfrt_pkg::FI_W-1:0]         frame_index,
  output logic                              read_needed,
  output logic                              write_back,
  output logic [pfrt_pkg::PAGE_W-1:0]       write_page,
  output logic [pfrt_pkg::PAGE_W-1:0]       frame_page,
  output logic [pfrt_pkg::PIN_W-1:0]        pin_count,
  output logic                              dirty_mark,
  output logic [pfrt_pkg::ST_W-1:0]         status,
  output logic [pfrt_pkg::WORD_W-1:0]       reads_total,
  output logic [pfrt_pkg::WORD_W-1:0]       writes_total,
  output logic                              last
);

  localparam int IW = pfrt_pkg::IDX_W;
  localparam int CW = pfrt_pkg::CNT_W;
  localparam int NF = pfrt_pkg::NUM_FRAMES;
  localparam logic [pfrt_pkg::PIN_W-1:0] PIN_W_ONE = 8'd1;

  typedef enum logic [2:0] {
    S_IDLE, S_MOD, S_SCAN1, S_DECIDE, S_SCAN2, S_FILL, S_FLUSH, S_CLOSE
  } state_t;

  // frame table
  logic [pfrt_pkg::PAGE_W-1:0] frame_pages [NF];
  logic                        frame_valid [NF];
  logic [pfrt_pkg::PIN_W-1:0]  pin_counts  [NF];
  logic                        dirty_marks [NF];
  logic [pfrt_pkg::WORD_W-1:0] use_stamps  [NF];
  logic [pfrt_pkg::WORD_W-1:0] use_counts  [NF];

  logic [pfrt_pkg::WORD_W-1:0] access_clock, read_counter, write_counter;
  logic [IW-1:0]               fifo_pointer, lfu_pointer;
  logic [1:0]                  policy;
  logic [4:0]                  frames_in_use;

  state_t                      state;
  logic [pfrt_pkg::OP_W-1:0]   op_r;
  logic [pfrt_pkg::PAGE_W-1:0] page_r;
  logic [3:0]                  sel_r;
  logic [CW-1:0]               n_r;
  logic [IW-1:0]               fptr, lptr;
  logic [IW-1:0]               idx;
  logic [CW-1:0]               step;
  logic                        hit_f, emp_f, vf, pinned_f, lfu_scan;
  logic [IW-1:0]               hit_i, emp_i, vi;
  logic [pfrt_pkg::WORD_W-1:0] best;

  logic                        out_free;
  logic [CW-1:0]               n_calc;
  logic [IW-1:0]               idx_wrap;
  logic                        idx_last, step_last;
  logic [1:0]                  pol_eff;
  pfrt_pkg::entry_t            entry;
  pfrt_pkg::cmp_t              cmp;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state != S_IDLE);
  assign out_free  = !out_valid || !out_stall;
  // policy three acts as fifo
  assign pol_eff   = (policy == 2'd3) ? pfrt_pkg::POL_FIFO : policy;

  always_comb begin
    if (frames_in_use == '0) begin
      n_calc = CW'(1);
    end else if (32'(frames_in_use) > NF) begin
      n_calc = CW'(NF);
    end else begin
      n_calc = CW'(frames_in_use);
    end
  end

  assign idx_last  = (CW'(idx) == n_r - CW'(1));
  assign idx_wrap  = idx_last ? '0 : idx + IW'(1);
  assign step_last = (step == n_r - CW'(1));

  // scan pass one ranks stamps, pass two ranks use counts under lfu (zero otherwise)
  always_comb begin
    entry.page  = frame_pages[idx];
    entry.valid = frame_valid[idx];
    entry.pin   = pin_counts[idx];
    if (state == S_SCAN2 && lfu_scan) begin
      entry.value = use_counts[idx];
    end else if (state == S_SCAN2) begin
      entry.value = '0;
    end else begin
      entry.value = use_stamps[idx];
    end
  end

  pfrt_cmp_unit u_cmp (
    .entry      (entry),
    .key        (page_r),
    .best       (best),
    .best_found (vf),
    .res        (cmp)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      out_valid     <= 1'b0;
      access_clock  <= '0;
      read_counter  <= '0;
      write_counter <= '0;
      fifo_pointer  <= '0;
      lfu_pointer   <= '0;
      policy        <= pfrt_pkg::POL_FIFO;
      frames_in_use <= 5'd16;
      for (int k = 0; k < NF; k++) begin
        frame_valid[k] <= 1'b0;
        pin_counts[k]  <= '0;
        dirty_marks[k] <= 1'b0;
        use_stamps[k]  <= '0;
        use_counts[k]  <= '0;
      end
    end else begin
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end

      if (cfg_valid) begin
        case (cfg_index)
          pfrt_pkg::REG_POLICY: policy        <= cfg_data[1:0];
          pfrt_pkg::REG_FRAMES: frames_in_use <= cfg_data;
          default: ;
        endcase
      end

      case (state)
        S_IDLE: begin
          if (in_valid) begin
            op_r     <= opcode;
            page_r   <= page_number;
            sel_r    <= frame_select;
            n_r      <= n_calc;
            fptr     <= fifo_pointer;
            lptr     <= lfu_pointer;
            idx      <= '0;
            hit_f    <= 1'b0;
            emp_f    <= 1'b0;
            vf       <= 1'b0;
            pinned_f <= 1'b0;
            case (opcode)
              pfrt_pkg::OP_PIN:                    state <= S_MOD;
              pfrt_pkg::OP_UNPIN, pfrt_pkg::OP_DIRTY,
              pfrt_pkg::OP_FORCE:                  state <= S_SCAN1;
              pfrt_pkg::OP_FLUSH,
              pfrt_pkg::OP_SHUTDOWN:               state <= S_FLUSH;
              default:                             state <= S_DECIDE;
            endcase
          end
        end

        // bring working copies of both pointers below the pool size
        S_MOD: begin
          if ({1'b0, CW'(fptr)} >= {1'b0, n_r}) begin
            fptr <= IW'(CW'(fptr) - n_r);
          end
          if ({1'b0, CW'(lptr)} >= {1'b0, n_r}) begin
            lptr <= IW'(CW'(lptr) - n_r);
          end
          if (CW'(fptr) < n_r && CW'(lptr) < n_r) begin
            state <= S_SCAN1;
          end
        end

        // hit, first empty frame and lru candidate in one pass
        S_SCAN1: begin
          if (cmp.hit && !hit_f) begin
            hit_f <= 1'b1;
            hit_i <= idx;
          end
          if (cmp.empty && !emp_f) begin
            emp_f <= 1'b1;
            emp_i <= idx;
          end
          if (cmp.less) begin
            vf   <= 1'b1;
            vi   <= idx;
            best <= entry.value;
          end
          idx <= idx_wrap;
          if (idx_last) begin
            state <= S_DECIDE;
          end
        end

        S_DECIDE: begin
          if (out_free) begin
            out_valid   <= 1'b1;
            last        <= 1'b1;
            read_needed <= 1'b0;
            write_back  <= 1'b0;
            write_page  <= '0;
            frame_index <= '0;
            frame_page  <= '0;
            pin_count   <= '0;
            dirty_mark  <= 1'b0;
            status      <= pfrt_pkg::ST_OK;
            reads_total <= read_counter;
            writes_total <= write_counter;
            state       <= S_IDLE;
            case (op_r)
              pfrt_pkg::OP_PIN: begin
                if (hit_f) begin
                  if (pin_counts[hit_i] != pfrt_pkg::PIN_MAX) begin
                    pin_counts[hit_i] <= pin_counts[hit_i] + 1'b1;
                    pin_count         <= pin_counts[hit_i] + 1'b1;
                  end else begin
                    pin_count         <= pin_counts[hit_i];
                  end
                  access_clock <= access_clock + 1'b1;
                  if (pol_eff == pfrt_pkg::POL_LRU) begin
                    use_stamps[hit_i] <= access_clock + 1'b1;
                  end
                  if (pol_eff == pfrt_pkg::POL_LFU) begin
                    use_counts[hit_i] <= use_counts[hit_i] + 1'b1;
                  end
                  frame_index <= pfrt_pkg::FI_W'(hit_i);
                  frame_page  <= frame_pages[hit_i];
                  dirty_mark  <= dirty_marks[hit_i];
                end else begin
                  // no beat yet, the fill step reports
                  out_valid <= 1'b0;
                  lfu_scan  <= 1'b0;
                  if (emp_f) begin
                    vf    <= 1'b1;
                    vi    <= emp_i;
                    state <= S_FILL;
                  end else if (pol_eff == pfrt_pkg::POL_LRU) begin
                    state <= S_FILL;
                  end else begin
                    vf       <= 1'b0;
                    step     <= '0;
                    lfu_scan <= (pol_eff == pfrt_pkg::POL_LFU);
                    idx      <= (pol_eff == pfrt_pkg::POL_LFU) ? lptr : fptr;
                    state    <= S_SCAN2;
                  end
                end
              end
              pfrt_pkg::OP_UNPIN, pfrt_pkg::OP_DIRTY, pfrt_pkg::OP_FORCE: begin
                if (!hit_f) begin
                  status <= pfrt_pkg::ST_NOT_RES;
                end else begin
                  frame_index <= pfrt_pkg::FI_W'(hit_i);
                  frame_page  <= frame_pages[hit_i];
                  pin_count   <= pin_counts[hit_i];
                  dirty_mark  <= dirty_marks[hit_i];
                  if (op_r == pfrt_pkg::OP_UNPIN) begin
                    if (pin_counts[hit_i] != '0) begin
                      pin_counts[hit_i] <= pin_counts[hit_i] - 1'b1;
                      pin_count         <= pin_counts[hit_i] - 1'b1;
                    end
                  end else if (op_r == pfrt_pkg::OP_DIRTY) begin
                    dirty_marks[hit_i] <= 1'b1;
                    dirty_mark         <= 1'b1;
                  end else begin
                    dirty_marks[hit_i] <= 1'b0;
                    dirty_mark         <= 1'b0;
                    write_back         <= 1'b1;
                    write_page         <= frame_pages[hit_i];
                    write_counter      <= write_counter + 1'b1;
                    writes_total       <= write_counter + 1'b1;
                  end
                end
              end
              pfrt_pkg::OP_QUERY: begin
                frame_index <= sel_r;
                if ((CW + 4)'(sel_r) >= (CW + 4)'(n_r) ||
                    !frame_valid[IW'(sel_r)]) begin
                  status <= pfrt_pkg::ST_EMPTY;
                end else begin
                  frame_page <= frame_pages[IW'(sel_r)];
                  pin_count  <= pin_counts[IW'(sel_r)];
                  dirty_mark <= dirty_marks[IW'(sel_r)];
                end
              end
              default: ;
            endcase
          end
        end

        // victim search from the rotating pointer
        S_SCAN2: begin
          if (lfu_scan) begin
            if (cmp.less) begin
              vf   <= 1'b1;
              vi   <= idx;
              best <= entry.value;
            end
          end else if (cmp.unpinned && !vf) begin
            vf <= 1'b1;
            vi <= idx;
          end
          idx  <= idx_wrap;
          step <= step + CW'(1);
          if (step_last) begin
            state <= S_FILL;
          end
        end

        S_FILL: begin
          if (out_free) begin
            out_valid   <= 1'b1;
            last        <= 1'b1;
            read_needed <= 1'b0;
            write_back  <= 1'b0;
            write_page  <= '0;
            frame_index <= '0;
            frame_page  <= '0;
            pin_count   <= '0;
            dirty_mark  <= 1'b0;
            status      <= pfrt_pkg::ST_NO_UNPIN;
            reads_total <= read_counter;
            writes_total <= write_counter;
            state       <= S_IDLE;
            if (vf) begin
              status       <= pfrt_pkg::ST_OK;
              read_needed  <= 1'b1;
              frame_index  <= pfrt_pkg::FI_W'(vi);
              frame_page   <= page_r;
              pin_count    <= PIN_W_ONE;
              if (dirty_marks[vi]) begin
                write_back    <= 1'b1;
                write_page    <= frame_pages[vi];
                write_counter <= write_counter + 1'b1;
                writes_total  <= write_counter + 1'b1;
              end
              if (lfu_scan) begin
                lfu_pointer <= (CW'(vi) == n_r - CW'(1)) ? '0 : vi + IW'(1);
              end
              fifo_pointer    <= (CW'(fptr) == n_r - CW'(1)) ? '0
                                 : fptr + IW'(1);
              frame_pages[vi] <= page_r;
              frame_valid[vi] <= 1'b1;
              pin_counts[vi]  <= PIN_W_ONE;
              dirty_marks[vi] <= 1'b0;
              use_counts[vi]  <= '0;
              use_stamps[vi]  <= access_clock + 1'b1;
              access_clock    <= access_clock + 1'b1;
              read_counter    <= read_counter + 1'b1;
              reads_total     <= read_counter + 1'b1;
            end
          end
        end

        // one beat per dirty unpinned frame
        S_FLUSH: begin
          if (frame_valid[idx] && pin_counts[idx] != '0) begin
            pinned_f <= 1'b1;
          end
          if (frame_valid[idx] && dirty_marks[idx] && pin_counts[idx] == '0) begin
            if (out_free) begin
              out_valid     <= 1'b1;
              last          <= 1'b0;
              read_needed   <= 1'b0;
              write_back    <= 1'b1;
              write_page    <= frame_pages[idx];
              frame_index   <= pfrt_pkg::FI_W'(idx);
              frame_page    <= frame_pages[idx];
              pin_count     <= pin_counts[idx];
              dirty_mark    <= 1'b0;
              status        <= pfrt_pkg::ST_OK;
              reads_total   <= read_counter;
              writes_total  <= write_counter + 1'b1;
              write_counter <= write_counter + 1'b1;
              dirty_marks[idx] <= 1'b0;
              idx <= idx_wrap;
              if (idx_last) begin
                state <= S_CLOSE;
              end
            end
          end else begin
            idx <= idx_wrap;
            if (idx_last) begin
              state <= S_CLOSE;
            end
          end
        end

        S_CLOSE: begin
          if (out_free) begin
            out_valid    <= 1'b1;
            last         <= 1'b1;
            read_needed  <= 1'b0;
            write_back   <= 1'b0;
            write_page   <= '0;
            frame_index  <= '0;
            frame_page   <= '0;
            pin_count    <= '0;
            dirty_mark   <= 1'b0;
            status       <= (op_r == pfrt_pkg::OP_SHUTDOWN && pinned_f)
                            ? pfrt_pkg::ST_PINNED_END : pfrt_pkg::ST_OK;
            reads_total  <= read_counter;
            writes_total <= write_counter;
            state        <= S_IDLE;
            if (op_r == pfrt_pkg::OP_SHUTDOWN) begin
              access_clock <= '0;
              fifo_pointer <= '0;
              lfu_pointer  <= '0;
              for (int k = 0; k < NF; k++) begin
                frame_valid[k] <= 1'b0;
                pin_counts[k]  <= '0;
                dirty_marks[k] <= 1'b0;
                use_stamps[k]  <= '0;
                use_counts[k]  <= '0;
              end
            end
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

  // scans never walk past the pool
  a_scan_in_pool: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN1 || state == S_SCAN2 || state == S_FLUSH) |-> (CW'(idx) < n_r))
    else $error("scan index beyond pool");

  // fifo pointer stays inside the pool after a fill
  a_fifo_wrap: assert property (@(posedge clk) disable iff (rst)
    (state == S_FILL && out_free && vf) |=> (CW'(fifo_pointer) < n_r))
    else $error("fifo pointer out of pool");

  // write counter moves by at most one per cycle
  a_wc_step: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> (write_counter == $past(write_counter) ||
                     write_counter == $past(write_counter) + 1'b1))
    else $error("write counter jumped");

  // a read beat always hands back a frame pinned once
  a_read_pin: assert property (@(posedge clk) disable iff (rst)
    (out_valid && read_needed) |-> (pin_count == PIN_W_ONE && last))
    else $error("read beat with bad pin count");

endmodule
